>>> hdl/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros shared by the mixer RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/mstm_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// mstm_pkg
// Types, constants and arithmetic helpers of the mono to surround matrix mixer.
//------------------------------------------------------------------------------
package mstm_pkg;

   // Sizes of the delay store.
   localparam int MAX_DELAY = 4096;
   localparam int DELAY_AW  = $clog2(MAX_DELAY);
   localparam int LENE_W    = DELAY_AW + 1;

   // Field and register widths.
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int WET_W    = 8;
   localparam int DRY_W    = 17;
   localparam int LEN_W    = 13;
   localparam int HIST_W   = 24;
   localparam int CSR_DW   = 18;
   localparam int CSR_IW   = 3;

   // Shared multiplier: 25 x 18 signed.
   localparam int MA_W   = 25;
   localparam int MB_W   = 18;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int RND_W  = ACC_W - 16;
   localparam int WIDE_W = RND_W + 1;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes.
   localparam logic CMD_PROCESS = 1'b0;
   localparam logic CMD_PASS    = 1'b1;

   // Register indexes.
   localparam logic [CSR_IW-1:0] REG_BAND_GAIN    = 3'd0;
   localparam logic [CSR_IW-1:0] REG_FEEDBACK_ONE = 3'd1;
   localparam logic [CSR_IW-1:0] REG_FEEDBACK_TWO = 3'd2;
   localparam logic [CSR_IW-1:0] REG_WET_GAIN     = 3'd3;
   localparam logic [CSR_IW-1:0] REG_DRY_GAIN     = 3'd4;
   localparam logic [CSR_IW-1:0] REG_DELAY_LENGTH = 3'd5;

   // Register reset values.
   localparam logic [WET_W-1:0] WET_GAIN_RESET     = 8'd90;
   localparam logic [DRY_W-1:0] DRY_GAIN_RESET     = 17'd46600;
   localparam logic [LEN_W-1:0] DELAY_LENGTH_RESET = 13'd344;

   // Saturation bounds.
   localparam logic signed [WIDE_W-1:0] S16_MAX = WIDE_W'(32767);
   localparam logic signed [WIDE_W-1:0] S16_MIN = -WIDE_W'(32768);
   localparam logic signed [WIDE_W-1:0] S24_MAX = WIDE_W'(8388607);
   localparam logic signed [WIDE_W-1:0] S24_MIN = -WIDE_W'(8388608);

   typedef struct packed {
      logic signed [COEF_W-1:0] band_gain;
      logic signed [COEF_W-1:0] feedback_one;
      logic signed [COEF_W-1:0] feedback_two;
      logic [WET_W-1:0]         wet_gain;
      logic [DRY_W-1:0]         dry_gain;
      logic [LEN_W-1:0]         delay_length;
   } mstm_cfg_type;

   // One classified transaction waiting for the back end.
   typedef struct packed {
      logic                       pass;
      logic signed [SAMPLE_W-1:0] sample;
   } mstm_item_type;

   // Divide by 2^16 with rounding half up.
   function automatic logic signed [RND_W-1:0] round16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] a;
      a = v + ACC_W'(32768);
      return a[ACC_W-1:16];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > S16_MAX) begin
         r = S16_MAX[SAMPLE_W-1:0];
      end else if (v < S16_MIN) begin
         r = S16_MIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [HIST_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
      logic signed [HIST_W-1:0] r;
      if (v > S24_MAX) begin
         r = S24_MAX[HIST_W-1:0];
      end else if (v < S24_MIN) begin
         r = S24_MIN[HIST_W-1:0];
      end else begin
         r = v[HIST_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/mstm_req_if.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// mstm_req_if
// Input channel: one mono sample and its command per transaction.
//------------------------------------------------------------------------------
interface mstm_req_if;
   import mstm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       command;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink   (input valid, input command, input sample, output ready);
endinterface

>>> hdl/mstm_rsp_if.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// mstm_rsp_if
// Result channel: one stereo pair per transaction.
//------------------------------------------------------------------------------
interface mstm_rsp_if;
   import mstm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> hdl/mstm_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
//------------------------------------------------------------------------------
// mstm_front
// Accepts input transactions, classifies them as pass-through or process and
// holds them in a short queue for the back end.
//------------------------------------------------------------------------------
module mstm_front (
   input  logic                    clock,
   input  logic                    reset,
   mstm_req_if.sink                req,
   input  logic                    clear_busy,
   output logic                    q_valid,
   output mstm_pkg::mstm_item_type q_item,
   input  logic                    q_pop
);
   import mstm_pkg::*;

   mstm_item_type     q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   mstm_item_type     new_item;

   // Accept while there is room and the delay store is not being cleared.
   assign req.ready = !clear_busy && (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;

   // Classify the incoming command.
   always_comb begin
      new_item.pass   = (req.command == CMD_PASS);
      new_item.sample = req.sample;
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = q_mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage carries payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   `ASSERT_NOW(a_pop_nonempty, clock, reset, q_pop, count_ff != '0, "pop from empty queue")
   `ASSERT_NEXT(a_count_grows, clock, reset, push && !q_pop, count_ff == $past(count_ff) + 1'b1, "queue count did not follow a push")

endmodule

>>> hdl/mstm_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
//------------------------------------------------------------------------------
// mstm_back
// Carries out queued transactions: bandpass recursion, circular delay store
// and matrix mix on one shared multiplier, with a registered result stage.
//------------------------------------------------------------------------------
module mstm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mstm_pkg::mstm_cfg_type  cfg,
   input  logic                    q_valid,
   input  mstm_pkg::mstm_item_type q_item,
   output logic                    q_pop,
   output logic                    clear_busy,
   mstm_rsp_if.source              rsp
);
   import mstm_pkg::*;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_MUL_B2  = 3'd2;
   localparam logic [2:0] ST_SUM_T   = 3'd3;
   localparam logic [2:0] ST_MUL_G   = 3'd4;
   localparam logic [2:0] ST_MUL_DRY = 3'd5;
   localparam logic [2:0] ST_MUL_WET = 3'd6;
   localparam logic [2:0] ST_MIX     = 3'd7;

   logic [2:0]                 state_ff, state_in;
   logic [DELAY_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [DELAY_AW-1:0]        pos_ff, pos_in;
   logic signed [HIST_W-1:0]   t1_ff, t1_in;
   logic signed [HIST_W-1:0]   t2_ff, t2_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [HIST_W-1:0]   t_ff, t_in;
   logic signed [SAMPLE_W-1:0] left_ff, left_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in;

   logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];
   logic signed [SAMPLE_W-1:0] mem_rd_ff;
   logic                       mem_we;
   logic                       mem_re;
   logic [DELAY_AW-1:0]        mem_waddr;
   logic signed [SAMPLE_W-1:0] mem_wdata;

   logic signed [MA_W-1:0]     op_a;
   logic signed [MB_W-1:0]     op_b;
   logic [LENE_W-1:0]          len_eff;
   logic [DELAY_AW-1:0]        pos_eff;
   logic [LENE_W-1:0]          pos_inc;
   logic signed [SAMPLE_W-1:0] y_val;
   logic signed [ACC_W-1:0]    wet_full;
   logic                       out_free;

   assign clear_busy    = (state_ff == ST_CLEAR);
   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.left_out  = left_ff;
   assign rsp.right_out = right_ff;

   // Effective ring length and position.
   always_comb begin
      if (cfg.delay_length == '0) begin
         len_eff = LENE_W'(1);
      end else if (32'(cfg.delay_length) > MAX_DELAY) begin
         len_eff = LENE_W'(MAX_DELAY);
      end else begin
         len_eff = LENE_W'(cfg.delay_length);
      end
      pos_eff = ({1'b0, pos_ff} >= len_eff) ? '0 : pos_ff;
      pos_inc = {1'b0, pos_ff} + LENE_W'(1);
   end

   // Band output and scaled wet product.
   assign y_val    = sat16(WIDE_W'(round16(ACC_W'(prod_ff))));
   assign wet_full = ACC_W'(prod_ff) <<< 9;

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_MUL_B2: begin
            op_a = MA_W'(t2_ff);
            op_b = cfg.feedback_two;
         end
         ST_MUL_G: begin
            op_a = MA_W'(t_ff) - MA_W'(t2_ff);
            op_b = cfg.band_gain;
         end
         ST_MUL_DRY: begin
            op_a = MA_W'(x_ff);
            op_b = signed'({1'b0, cfg.dry_gain});
         end
         ST_MUL_WET: begin
            op_a = MA_W'(mem_rd_ff);
            op_b = signed'(MB_W'({1'b0, cfg.wet_gain}));
         end
         default: begin
            op_a = MA_W'(t1_ff);
            op_b = cfg.feedback_one;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      pos_in       = pos_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      x_in         = x_ff;
      acc_in       = acc_ff;
      prod_in      = (state_ff == ST_MIX) ? prod_ff : PROD_W'(op_a) * PROD_W'(op_b);
      t_in         = t_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = y_val;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == DELAY_AW'(MAX_DELAY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.pass) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     left_in      = q_item.sample;
                     right_in     = q_item.sample;
                  end
               end else begin
                  // First feedback product is formed in this cycle.
                  q_pop    = 1'b1;
                  x_in     = q_item.sample;
                  mem_re   = 1'b1;
                  pos_in   = pos_eff;
                  state_in = ST_MUL_B2;
               end
            end
         end
         ST_MUL_B2: begin
            acc_in   = prod_ff;
            state_in = ST_SUM_T;
         end
         ST_SUM_T: begin
            t_in = sat24(WIDE_W'(x_ff) -
                         WIDE_W'(round16(ACC_W'(acc_ff) + ACC_W'(prod_ff))));
            state_in = ST_MUL_G;
         end
         ST_MUL_G: begin
            state_in = ST_MUL_DRY;
         end
         ST_MUL_DRY: begin
            // Store the band output and advance the filter and ring.
            mem_we   = 1'b1;
            t2_in    = t1_ff;
            t1_in    = t_ff;
            pos_in   = (pos_inc >= len_eff) ? '0 : pos_inc[DELAY_AW-1:0];
            state_in = ST_MUL_WET;
         end
         ST_MUL_WET: begin
            acc_in   = prod_ff;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               left_in  = sat16(WIDE_W'(round16(ACC_W'(acc_ff) + wet_full)));
               right_in = sat16(WIDE_W'(round16(ACC_W'(acc_ff) - wet_full)));
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         pos_ff       <= '0;
         t1_ff        <= '0;
         t2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pos_ff       <= pos_in;
         t1_ff        <= t1_in;
         t2_ff        <= t2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      t_ff     <= t_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   // Delay store write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // Delay store read port.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rd_ff <= mem[pos_eff];
      end
   end

   `ASSERT_NOW(a_pop_only_idle, clock, reset, q_pop, (state_ff == ST_IDLE) && q_valid, "pop outside idle state")
   `ASSERT_NEXT(a_pos_in_ring, clock, reset, state_ff == ST_MUL_DRY, {1'b0, pos_ff} < len_eff, "ring position beyond length")
   `ASSERT_NEXT(a_mix_delivers, clock, reset, (state_ff == ST_MIX) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "mix result not presented")

endmodule

>>> hdl/mono_to_surround_matrix_mixer.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// mono_to_surround_matrix_mixer
// Mono to stereo pseudo-surround mixer: bandpass, circular delay and matrix.
//------------------------------------------------------------------------------
// A pass-through transaction goes from the queue straight to the result stage,
// so a stream of them runs at one per clock while each result is taken. No
// new transaction enters the back end until a process result is registered, as
// the single 25 x 18 multiplier forms the five products (two feedback terms,
// band gain, dry gain, wet gain) one after another. The input queue holds two
// transactions and the result stage holds one, so the front end keeps accepting
// while a result waits. After reset the delay store is cleared one entry per
// cycle, 4096 entries in all, during which no transaction is accepted; register
// writes are taken throughout and must only be made while the block is idle.
module mono_to_surround_matrix_mixer (
   input  logic                          clock,
   input  logic                          reset,
   mstm_req_if.sink                      req_chan,
   mstm_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [mstm_pkg::CSR_IW-1:0]   csr_index,
   input  logic [mstm_pkg::CSR_DW-1:0]   csr_wr_data
);
   import mstm_pkg::*;

   mstm_cfg_type  cfg_ff, cfg_in;
   logic          q_valid;
   mstm_item_type q_item;
   logic          q_pop;
   logic          clear_busy;

   // Register file write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_BAND_GAIN:    cfg_in.band_gain    = signed'(csr_wr_data[COEF_W-1:0]);
            REG_FEEDBACK_ONE: cfg_in.feedback_one = signed'(csr_wr_data[COEF_W-1:0]);
            REG_FEEDBACK_TWO: cfg_in.feedback_two = signed'(csr_wr_data[COEF_W-1:0]);
            REG_WET_GAIN:     cfg_in.wet_gain     = csr_wr_data[WET_W-1:0];
            REG_DRY_GAIN:     cfg_in.dry_gain     = csr_wr_data[DRY_W-1:0];
            REG_DELAY_LENGTH: cfg_in.delay_length = csr_wr_data[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_gain    <= '0;
         cfg_ff.feedback_one <= '0;
         cfg_ff.feedback_two <= '0;
         cfg_ff.wet_gain     <= WET_GAIN_RESET;
         cfg_ff.dry_gain     <= DRY_GAIN_RESET;
         cfg_ff.delay_length <= DELAY_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: acceptance, classification and queue.
   mstm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .clear_busy (clear_busy),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back end: arithmetic sequencer, delay store and result stage.
   mstm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp        (rsp_chan)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the mono to surround matrix mixer. A bit-true
// predictor of the bandpass, the circular delay and the output matrix works out
// each stereo pair as a transaction is accepted. Results are compared in order
// while both channels idle and stall at random, under directed and random
// register settings.
//------------------------------------------------------------------------------
module tb;
   import mstm_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 60;
   localparam int PHASE_COUNT   = 10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_wr_en;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wr_data;

   mstm_req_if req_bus ();
   mstm_rsp_if rsp_bus ();

   mono_to_surround_matrix_mixer uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor copy of the registers.
   logic signed [COEF_W-1:0] band_gain_q;
   logic signed [COEF_W-1:0] fb_one_q;
   logic signed [COEF_W-1:0] fb_two_q;
   logic [WET_W-1:0]         wet_q;
   logic [DRY_W-1:0]         dry_q;
   logic [LEN_W-1:0]         ring_len;

   // Predictor copy of the filter history and the delay ring.
   logic signed [HIST_W-1:0]   hist_t1;
   logic signed [HIST_W-1:0]   hist_t2;
   logic signed [SAMPLE_W-1:0] ring_mem [MAX_DELAY];
   int                         ring_pos;

   stereo_pair_type pending_pairs[$];
   int              mismatches = 0;
   int              rsp_hold   = 0;
   bit              steady     = 1'b0;

   always #10 clock = ~clock;

   // Overall limit on the run.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) begin
         return 0;
      end else if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic longint round_q16(input longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void reset_model();
      band_gain_q = '0;
      fb_one_q    = '0;
      fb_two_q    = '0;
      wet_q       = WET_GAIN_RESET;
      dry_q       = DRY_GAIN_RESET;
      ring_len    = DELAY_LENGTH_RESET;
      hist_t1     = '0;
      hist_t2     = '0;
      ring_pos    = 0;
      foreach (ring_mem[i]) ring_mem[i] = '0;
   endfunction

   function automatic void store_setting(input logic [CSR_IW-1:0] idx,
                                         input logic [CSR_DW-1:0] data);
      case (idx)
         REG_BAND_GAIN: begin
            band_gain_q = data[COEF_W-1:0];
         end
         REG_FEEDBACK_ONE: begin
            fb_one_q = data[COEF_W-1:0];
         end
         REG_FEEDBACK_TWO: begin
            fb_two_q = data[COEF_W-1:0];
         end
         REG_WET_GAIN: begin
            wet_q = data[WET_W-1:0];
         end
         REG_DRY_GAIN: begin
            dry_q = data[DRY_W-1:0];
         end
         REG_DELAY_LENGTH: begin
            ring_len = data[LEN_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Works out the stereo pair of one transaction and advances the state.
   function automatic stereo_pair_type predict_stereo(input logic cmd,
                                                      input logic signed [SAMPLE_W-1:0] x);
      stereo_pair_type p;
      longint xs, t1, t2, t, y, s, dry, wet, lv, rv;
      int len;
      xs = x;
      if (cmd == CMD_PASS) begin
         p.left  = x;
         p.right = x;
         return p;
      end
      t1 = hist_t1;
      t2 = hist_t2;
      t  = xs - round_q16(longint'($signed(fb_one_q)) * t1 + longint'($signed(fb_two_q)) * t2);
      t  = clip(t, -64'sd8388608, 64'sd8388607);
      y  = clip(round_q16(longint'($signed(band_gain_q)) * (t - t2)), -64'sd32768, 64'sd32767);
      hist_t2 = hist_t1;
      hist_t1 = t[HIST_W-1:0];

      // A zero length behaves as one, an overlong one as the full store.
      len = ring_len;
      if (len == 0) len = 1;
      if (len > MAX_DELAY) len = MAX_DELAY;
      if (ring_pos >= len) ring_pos = 0;
      s = ring_mem[ring_pos];
      ring_mem[ring_pos] = y[SAMPLE_W-1:0];
      ring_pos++;
      if (ring_pos >= len) ring_pos = 0;

      dry = longint'(dry_q) * xs;
      wet = longint'(wet_q) * 512 * s;
      lv  = clip(round_q16(dry + wet), -64'sd32768, 64'sd32767);
      rv  = clip(round_q16(dry - wet), -64'sd32768, 64'sd32767);
      p.left  = lv[SAMPLE_W-1:0];
      p.right = rv[SAMPLE_W-1:0];
      return p;
   endfunction

   // Receiver side: ready drops for random stretches.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold      <= rsp_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 7) == 0) rsp_hold <= pick_gap();
      end
   end

   // Each accepted result is checked against the oldest expected pair.
   always @(posedge clock) begin
      stereo_pair_type exp_pair;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pairs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, actual left %0d right %0d", $time,
                     rsp_bus.left_out, rsp_bus.right_out);
         end else begin
            exp_pair = pending_pairs.pop_front();
            if (rsp_bus.left_out !== exp_pair.left) begin
               mismatches++;
               $display("%0t: left_out expected %0d, actual %0d", $time,
                        exp_pair.left, rsp_bus.left_out);
            end
            if (rsp_bus.right_out !== exp_pair.right) begin
               mismatches++;
               $display("%0t: right_out expected %0d, actual %0d", $time,
                        exp_pair.right, rsp_bus.right_out);
            end
         end
      end
   end

   // Sends one transaction, records its expected pair, then idles at random.
   task automatic send_sample(input logic cmd, input logic signed [SAMPLE_W-1:0] x);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.sample  <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_pairs.push_back(predict_stereo(cmd, x));
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected pair has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      store_setting(idx, data);
   endtask

   // Writes all six registers; called only while the block is idle.
   task automatic apply_settings(input mstm_cfg_type c);
      write_reg(REG_BAND_GAIN,    CSR_DW'(c.band_gain));
      write_reg(REG_FEEDBACK_ONE, CSR_DW'(c.feedback_one));
      write_reg(REG_FEEDBACK_TWO, CSR_DW'(c.feedback_two));
      write_reg(REG_WET_GAIN,     CSR_DW'(c.wet_gain));
      write_reg(REG_DRY_GAIN,     CSR_DW'(c.dry_gain));
      write_reg(REG_DELAY_LENGTH, CSR_DW'(c.delay_length));
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_W'($urandom_range(0, 200) - 100);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Settings for one random phase: a stable filter, fully random values, or the extremes.
   function automatic mstm_cfg_type make_settings(input int kind);
      mstm_cfg_type c;
      int b2;
      case (kind)
         0: begin
            b2 = $urandom_range(30000, 64000);
            c.feedback_two = COEF_W'(b2);
            c.feedback_one = COEF_W'($urandom_range(0, 65535 + b2));
            if ($urandom_range(0, 1)) c.feedback_one = -c.feedback_one;
            c.band_gain    = COEF_W'($urandom_range(0, 40000));
            if ($urandom_range(0, 1)) c.band_gain = -c.band_gain;
            c.wet_gain     = WET_W'($urandom_range(0, 128));
            c.dry_gain     = DRY_W'($urandom_range(0, 65536));
            c.delay_length = LEN_W'($urandom_range(1, 64));
         end
         1: begin
            c.band_gain    = COEF_W'($urandom);
            c.feedback_one = COEF_W'($urandom);
            c.feedback_two = COEF_W'($urandom);
            c.wet_gain     = WET_W'($urandom);
            c.dry_gain     = DRY_W'($urandom);
            c.delay_length = ($urandom_range(0, 1)) ? LEN_W'($urandom) :
                                                      LEN_W'($urandom_range(0, 20));
         end
         2: begin
            c.band_gain    = 18'sh20000;
            c.feedback_one = 18'sh20000;
            c.feedback_two = 18'sh20000;
            c.wet_gain     = '0;
            c.dry_gain     = '0;
            c.delay_length = LEN_W'(MAX_DELAY);
         end
         default: begin
            c.band_gain    = 18'sh1FFFF;
            c.feedback_one = 18'sh1FFFF;
            c.feedback_two = 18'sh1FFFF;
            c.wet_gain     = '1;
            c.dry_gain     = '1;
            c.delay_length = '1;
         end
      endcase
      return c;
   endfunction

   // Reset values: the filter is silent, so only the dry path shows.
   task automatic test_reset_defaults();
      send_sample(CMD_PROCESS, 16'sh7FFF);
      send_sample(CMD_PROCESS, 16'sh8000);
      send_sample(CMD_PROCESS, 16'sh0000);
      send_sample(CMD_PROCESS, -16'sd1);
      send_sample(CMD_PASS,    16'sh8000);
      drain_results();
   endtask

   // Largest coefficients and gains beyond range, with a zero ring length;
   // a pass-through transaction in between must leave the state alone.
   task automatic test_gain_extremes();
      mstm_cfg_type c;
      c.band_gain    = 18'sh1FFFF;
      c.feedback_one = 18'sh20000;
      c.feedback_two = 18'sh1FFFF;
      c.wet_gain     = '1;
      c.dry_gain     = '1;
      c.delay_length = '0;
      apply_settings(c);
      send_sample(CMD_PROCESS, 16'sh7FFF);
      send_sample(CMD_PROCESS, 16'sh8000);
      send_sample(CMD_PROCESS, 16'sh7FFF);
      send_sample(CMD_PASS,    16'sh7FFF);
      send_sample(CMD_PROCESS, 16'sh8000);
      send_sample(CMD_PROCESS, 16'sh0000);
      send_sample(CMD_PROCESS, -16'sd1);
      drain_results();
   endtask

   // Overlong length, then a length lowered below the current position.
   task automatic test_length_limits();
      mstm_cfg_type c;
      c.band_gain    = 18'sd65536;
      c.feedback_one = '0;
      c.feedback_two = '0;
      c.wet_gain     = 8'd128;
      c.dry_gain     = 17'd65536;
      c.delay_length = '1;
      apply_settings(c);
      send_sample(CMD_PROCESS, 16'sd1000);
      send_sample(CMD_PROCESS, -16'sd2000);
      drain_results();
      c.delay_length = 13'd12;
      apply_settings(c);
      repeat (6) send_sample(CMD_PROCESS, pick_sample());
      drain_results();
      c.delay_length = 13'd4;
      apply_settings(c);
      repeat (3) send_sample(CMD_PROCESS, pick_sample());
      drain_results();
   endtask

   // Random phases under changing settings; one runs without any idling and
   // the sender stops halfway through some to let the results drain.
   task automatic test_random_phases();
      int kinds [PHASE_COUNT] = '{0, 1, 0, 2, 0, 1, 0, 3, 0, 1};
      logic cmd;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_settings(make_settings(kinds[p]));
         steady = (p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 2) == 0)) begin
               drain_results();
            end
            cmd = ($urandom_range(0, 4) == 0) ? CMD_PASS : CMD_PROCESS;
            send_sample(cmd, pick_sample());
         end
         drain_results();
         steady = 1'b0;
      end
   endtask

   // Main sequence.
   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_PROCESS;
      req_bus.sample  <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= REG_BAND_GAIN;
      csr_wr_data     <= '0;
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_gain_extremes();
      test_length_limits();
      test_random_phases();

      drain_results();
      if (mismatches == 0 && pending_pairs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> mono_to_surround_matrix_mixer.f
+incdir+hdl
hdl/mstm_pkg.sv
hdl/mstm_req_if.sv
hdl/mstm_rsp_if.sv
hdl/mstm_front.sv
hdl/mstm_back.sv
hdl/mono_to_surround_matrix_mixer.sv
tb/tb.sv
